// ----- rtl/priority_message_queue_assert.svh -----
// Assertion macros shared by the priority message queue RTL.
`ifndef PRIORITY_MESSAGE_QUEUE_ASSERT_SVH
`define PRIORITY_MESSAGE_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication on clk_i, disabled while rst_ni is low.
`define PMQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication on clk_i, disabled while rst_ni is low.
`define PMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PMQ_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PMQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/pmq_pkg.sv -----
// Shared types and constants of the priority message queue.
package pmq_pkg;

  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned LEN_W      = 14;
  localparam int unsigned OPRIO_W    = 15;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned BYTES_W    = 19;
  localparam int unsigned SIZE_W     = 14;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 19;

  localparam logic ACT_SEND = 1'b0;
  localparam logic ACT_RECV = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_MESSAGES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_SIZE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BYTE_BUDGET  = 2'd2;

  localparam logic [CNT_W-1:0]   RST_MAX_MESSAGES = 6'd32;
  localparam logic [SIZE_W-1:0]  RST_MAX_SIZE     = 14'd8192;
  localparam logic [BYTES_W-1:0] RST_BYTE_BUDGET  = 19'd262144;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_EMPTY       = 3'd2,
    ST_TOO_BIG     = 3'd3,
    ST_BAD_PRIO    = 3'd4,
    ST_OVER_BUDGET = 3'd5
  } status_e;

  typedef struct packed {
    logic [CNT_W-1:0]   max_messages;
    logic [SIZE_W-1:0]  max_size;
    logic [BYTES_W-1:0] byte_budget;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic [FIELD_W-1:0] msg_priority;
    logic [FIELD_W-1:0] msg_length;
    logic [FIELD_W-1:0] msg_tag;
    logic [FIELD_W-1:0] buffer_length;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [LEN_W-1:0]   out_length;
    logic [OPRIO_W-1:0] out_priority;
    logic [TAG_W-1:0]   out_tag;
    logic [CNT_W-1:0]   message_count;
    logic [BYTES_W-1:0] bytes_queued;
    logic               can_read;
    logic               can_write;
    logic               became_nonempty;
  } rsp_t;

endpackage

// ----- rtl/pmq_req_if.sv -----
// Request channel: one send or receive operation per transaction.
interface pmq_req_if import pmq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [FIELD_W-1:0] msg_priority;
  logic [FIELD_W-1:0] msg_length;
  logic [FIELD_W-1:0] msg_tag;
  logic [FIELD_W-1:0] buffer_length;

  modport source (
    output valid, action, msg_priority, msg_length, msg_tag, buffer_length,
    input  ready
  );
  modport sink (
    input  valid, action, msg_priority, msg_length, msg_tag, buffer_length,
    output ready
  );
endinterface

// ----- rtl/pmq_rsp_if.sv -----
// Response channel: one result per request transaction.
interface pmq_rsp_if import pmq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [LEN_W-1:0]    out_length;
  logic [OPRIO_W-1:0]  out_priority;
  logic [TAG_W-1:0]    out_tag;
  logic [CNT_W-1:0]    message_count;
  logic [BYTES_W-1:0]  bytes_queued;
  logic                can_read;
  logic                can_write;
  logic                became_nonempty;

  modport source (
    output valid, status, out_length, out_priority, out_tag, message_count,
           bytes_queued, can_read, can_write, became_nonempty,
    input  ready
  );
  modport sink (
    input  valid, status, out_length, out_priority, out_tag, message_count,
           bytes_queued, can_read, can_write, became_nonempty,
    output ready
  );
endinterface

// ----- rtl/pmq_store.sv -----
// Slot memory: one write port, one read port with registered read data.
module pmq_store #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5,
  parameter int unsigned DW    = 45
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pmq_seq.sv -----
// Operation sequencer: checks, insertion shift, pop shift and result build.
module pmq_seq import pmq_pkg::*; #(
  parameter int unsigned DEPTH       = 32,
  parameter int unsigned PRIO_LEVELS = 32768,
  parameter int unsigned MAX_SIZE    = 8192,
  parameter int unsigned AW          = 5,
  parameter int unsigned DW          = 45
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  req_t          req_i,
  output logic          req_ready_o,
  input  cfg_t          cfg_i,
  input  logic          rsp_free_i,
  output logic          done_o,
  output rsp_t          rsp_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [DW-1:0] mem_wdata_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [DW-1:0] mem_rdata_i
);

  localparam int unsigned PW     = $clog2(PRIO_LEVELS);
  localparam int unsigned CntMax = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] CapLimit =
    CNT_W'((DEPTH > CntMax) ? CntMax : DEPTH);
  localparam logic [FIELD_W-1:0] SizeLimit = FIELD_W'(MAX_SIZE);
  localparam logic [FIELD_W:0]   PrioLimit = (FIELD_W + 1)'(PRIO_LEVELS);

  typedef struct packed {
    logic [PW-1:0]    prio;
    logic [LEN_W-1:0] len;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SHIFT,
    S_INSERT,
    S_POP_HEAD,
    S_POP_MOVE,
    S_FINISH
  } state_e;

  state_e             state_q;
  req_t               req_q;
  logic [AW-1:0]      pos_q;
  logic [CNT_W-1:0]   count_q;
  logic [BYTES_W-1:0] bytes_q;
  status_e            status_q;
  logic               became_q;
  entry_t             head_q;

  entry_t             rd_entry;
  entry_t             new_entry;
  logic               prio_lt;
  logic [CNT_W-1:0]   eff_cap;
  logic [FIELD_W-1:0] eff_max;
  status_e            chk_status;
  logic [BYTES_W-1:0] pop_bytes;

  assign rd_entry  = entry_t'(mem_rdata_i);
  assign new_entry = '{prio: req_q.msg_priority[PW-1:0],
                       len:  req_q.msg_length[LEN_W-1:0],
                       tag:  req_q.msg_tag};

  // Shared priority comparator of the shift loop
  assign prio_lt = rd_entry.prio < new_entry.prio;

  assign eff_cap = (cfg_i.max_messages > CapLimit) ? CapLimit : cfg_i.max_messages;
  assign eff_max = ({{(FIELD_W-SIZE_W){1'b0}}, cfg_i.max_size} > SizeLimit) ?
                   SizeLimit : {{(FIELD_W-SIZE_W){1'b0}}, cfg_i.max_size};

  assign pop_bytes = (bytes_q >= {{(BYTES_W-LEN_W){1'b0}}, rd_entry.len}) ?
                     bytes_q - {{(BYTES_W-LEN_W){1'b0}}, rd_entry.len} : '0;

  always_comb begin
    chk_status = ST_OK;
    if (req_q.action == ACT_SEND) begin
      priority if ({1'b0, req_q.msg_priority} >= PrioLimit) begin
        chk_status = ST_BAD_PRIO;
      end else if (count_q >= eff_cap) begin
        chk_status = ST_FULL;
      end else if (req_q.msg_length > eff_max) begin
        chk_status = ST_TOO_BIG;
      end else if (({1'b0, bytes_q} + {{(BYTES_W+1-FIELD_W){1'b0}}, req_q.msg_length})
                   > {1'b0, cfg_i.byte_budget}) begin
        chk_status = ST_OVER_BUDGET;
      end else begin
        chk_status = ST_OK;
      end
    end else begin
      priority if (count_q == '0) begin
        chk_status = ST_EMPTY;
      end else if (req_q.buffer_length < eff_max) begin
        chk_status = ST_TOO_BIG;
      end else begin
        chk_status = ST_OK;
      end
    end
  end

  // Memory port control
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q;
    mem_wdata_o = new_entry;
    mem_raddr_o = '0;
    unique case (state_q)
      S_CHECK: begin
        // A receive fetches the head, a send the tail entry
        if (req_q.action == ACT_RECV) begin
          mem_raddr_o = '0;
        end else begin
          mem_raddr_o = AW'(count_q - CNT_W'(1));
        end
      end
      S_SHIFT: begin
        mem_we_o = 1'b1;
        if (prio_lt) begin
          mem_wdata_o = rd_entry;
          mem_raddr_o = pos_q - AW'(2);
        end
      end
      S_INSERT: begin
        mem_we_o = 1'b1;
      end
      S_POP_HEAD: begin
        mem_raddr_o = AW'(1);
      end
      S_POP_MOVE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q - AW'(1);
        mem_wdata_o = rd_entry;
        mem_raddr_o = pos_q + AW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      req_q    <= '0;
      pos_q    <= '0;
      count_q  <= '0;
      bytes_q  <= '0;
      status_q <= ST_OK;
      became_q <= 1'b0;
      head_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            req_q   <= req_i;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          status_q <= chk_status;
          became_q <= 1'b0;
          head_q   <= '0;
          if (chk_status != ST_OK) begin
            state_q <= S_FINISH;
          end else if (req_q.action == ACT_SEND) begin
            became_q <= (count_q == '0);
            pos_q    <= AW'(count_q);
            state_q  <= (count_q == '0) ? S_INSERT : S_SHIFT;
          end else begin
            state_q <= S_POP_HEAD;
          end
        end
        S_SHIFT: begin
          if (prio_lt) begin
            pos_q <= pos_q - AW'(1);
            if (pos_q == AW'(1)) begin
              state_q <= S_INSERT;
            end
          end else begin
            count_q <= count_q + CNT_W'(1);
            bytes_q <= bytes_q + BYTES_W'(req_q.msg_length[LEN_W-1:0]);
            state_q <= S_FINISH;
          end
        end
        S_INSERT: begin
          count_q <= count_q + CNT_W'(1);
          bytes_q <= bytes_q + BYTES_W'(req_q.msg_length[LEN_W-1:0]);
          state_q <= S_FINISH;
        end
        S_POP_HEAD: begin
          head_q  <= rd_entry;
          count_q <= count_q - CNT_W'(1);
          bytes_q <= pop_bytes;
          pos_q   <= AW'(1);
          state_q <= (count_q == CNT_W'(1)) ? S_FINISH : S_POP_MOVE;
        end
        S_POP_MOVE: begin
          // count_q already holds the new count, which is also the last source index
          if (CNT_W'(pos_q) == count_q) begin
            state_q <= S_FINISH;
          end else begin
            pos_q <= pos_q + AW'(1);
          end
        end
        S_FINISH: begin
          if (rsp_free_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign done_o      = (state_q == S_FINISH) && rsp_free_i;

  always_comb begin
    rsp_o.status          = status_q;
    rsp_o.out_length      = head_q.len;
    rsp_o.out_priority    = OPRIO_W'(head_q.prio);
    rsp_o.out_tag         = head_q.tag;
    rsp_o.message_count   = count_q;
    rsp_o.bytes_queued    = bytes_q;
    rsp_o.can_read        = (count_q != '0);
    rsp_o.can_write       = (count_q < eff_cap);
    rsp_o.became_nonempty = became_q;
  end

endmodule

// ----- rtl/priority_message_queue.sv -----
// Top level of the priority message queue: config registers, store, sequencer, result register.
//
// Usage: a request transaction on req_i is a send (action 0: priority, length, tag) or
// a receive (action 1: buffer_length). Each request gives exactly one response
// transaction on rsp_o with status, popped message, count, queued bytes and flags.
// Configuration (capacity, largest size, byte budget) is written through the
// cfg_we_i / cfg_idx_i / cfg_data_i port while no operation is in flight.
// From request acceptance, a rejected operation goes from the check straight to
// the response; a send moves each lower-priority entry that it passes back by one
// slot and is then written into the freed slot; a receive pops the head and moves up the rest.
// The slot memory, with one write and one read port, moves one entry per cycle;
// req_i.ready is low for the whole operation and rises
// at the edge that loads the response, so a new request may follow at once.
// Reset empties the queue (count and byte total to zero) and restores the
// configuration to 32 messages, 8192 bytes and a 262144-byte budget.
// When the receiver stalls, the response register holds its value; the next
// request is still accepted and worked on, and its result waits in the
// sequencer until the register is free.
module priority_message_queue import pmq_pkg::*; #(
  parameter int unsigned DEPTH       = 32,
  parameter int unsigned PRIO_LEVELS = 32768,
  parameter int unsigned MAX_SIZE    = 8192
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pmq_req_if.sink               req_i,
  pmq_rsp_if.source             rsp_o
);

`include "priority_message_queue_assert.svh"

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PW = $clog2(PRIO_LEVELS);
  localparam int unsigned DW = PW + LEN_W + TAG_W;

  cfg_t          cfg_q;
  req_t          req;
  rsp_t          seq_rsp;
  rsp_t          rsp_q;
  logic          rsp_valid_q;
  logic          rsp_free;
  logic          seq_done;
  logic          seq_ready;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  // Configuration registers: unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_messages <= RST_MAX_MESSAGES;
      cfg_q.max_size     <= RST_MAX_SIZE;
      cfg_q.byte_budget  <= RST_BYTE_BUDGET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_MAX_MESSAGES: cfg_q.max_messages <= cfg_data_i[CNT_W-1:0];
        CFG_IDX_MAX_SIZE:     cfg_q.max_size     <= cfg_data_i[SIZE_W-1:0];
        CFG_IDX_BYTE_BUDGET:  cfg_q.byte_budget  <= cfg_data_i[BYTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign req = '{action:        req_i.action,
                 msg_priority:  req_i.msg_priority,
                 msg_length:    req_i.msg_length,
                 msg_tag:       req_i.msg_tag,
                 buffer_length: req_i.buffer_length};
  assign req_i.ready = seq_ready;

  pmq_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pmq_seq #(
    .DEPTH       (DEPTH),
    .PRIO_LEVELS (PRIO_LEVELS),
    .MAX_SIZE    (MAX_SIZE),
    .AW          (AW),
    .DW          (DW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_i       (req),
    .req_ready_o (seq_ready),
    .cfg_i       (cfg_q),
    .rsp_free_i  (rsp_free),
    .done_o      (seq_done),
    .rsp_o       (seq_rsp),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Response register: load on completion, drop once the transaction is taken
  assign rsp_free = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (seq_done) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      rsp_q <= seq_rsp;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = rsp_q.status;
  assign rsp_o.out_length      = rsp_q.out_length;
  assign rsp_o.out_priority    = rsp_q.out_priority;
  assign rsp_o.out_tag         = rsp_q.out_tag;
  assign rsp_o.message_count   = rsp_q.message_count;
  assign rsp_o.bytes_queued    = rsp_q.bytes_queued;
  assign rsp_o.can_read        = rsp_q.can_read;
  assign rsp_o.can_write       = rsp_q.can_write;
  assign rsp_o.became_nonempty = rsp_q.became_nonempty;

  // The sequencer goes busy straight after taking a request
  `PMQ_ASSERT_NEXT(a_busy_after_accept, req_i.valid && req_i.ready, !req_i.ready, "ready after accept")
  // A result is only released into a free response register
  `PMQ_ASSERT_IMPLY(a_done_needs_room, seq_done, rsp_free, "result overwrote pending response")
  // An empty-to-nonempty flag only comes with a successful send leaving one message
  `PMQ_ASSERT_IMPLY(a_became_one, rsp_valid_q && rsp_q.became_nonempty, (rsp_q.message_count == 6'd1) && (rsp_q.status == ST_OK), "bad became_nonempty")
  // The readable flag follows the reported count
  `PMQ_ASSERT_IMPLY(a_can_read, rsp_valid_q, rsp_q.can_read == (rsp_q.message_count != '0), "can_read mismatch")

endmodule
